FILE: src/psd_pkg.sv
// Package for the point to segment distance core: widths, result codes and
// the records carried along the cell chains. Used by every other file.
`default_nettype none
package psd_pkg;

  localparam int CoordW  = 16;             // input coordinate width
  localparam int DiffW   = CoordW + 1;     // coordinate difference
  localparam int ProdW   = 2 * DiffW;      // product of two differences
  localparam int SumW    = ProdW + 1;      // signed sum of two products
  localparam int LenW    = 33;             // squared length, squared distance
  localparam int AcrW    = 34;             // magnitude of the cross product
  localparam int HalfW   = AcrW / 2;       // cross magnitude split for squaring
  localparam int Cross2W = 2 * AcrW;       // squared cross product
  localparam int FracW   = 16;             // 2^16 scale of the squared distance
  localparam int DistW   = 25;             // result width
  localparam int QuotW   = 2 * DistW;      // quotient, radicand of the root
  localparam int DivNumW = QuotW + LenW;   // dividend bits that can be nonzero
  localparam int SqRemW  = DistW + 2;      // square root partial remainder

  typedef enum logic [1:0] {
    PartStart    = 2'd0,
    PartInterior = 2'd1,
    PartEnd      = 2'd2
  } part_e;

  // one division cell's view: remainder, dividend bits still to shift in
  // (quotient bits shift in at the bottom of the same word), divisor
  typedef struct packed {
    logic              valid;
    part_e             part;
    logic [LenW-1:0]   rem;
    logic [QuotW-1:0]  num;
    logic [LenW-1:0]   den;
  } div_t;

  // one square root cell's view
  typedef struct packed {
    logic              valid;
    part_e             part;
    logic [QuotW-1:0]  rad;
    logic [SqRemW-1:0] rem;
    logic [DistW-1:0]  root;
  } sqrt_t;

endpackage
`default_nettype wire

FILE: src/psd_if.sv
// Valid/ready channel interfaces of the point to segment distance core.
// Depends on psd_pkg for the field widths.
`default_nettype none
interface psd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [psd_pkg::CoordW-1:0]   point_x;
  logic signed [psd_pkg::CoordW-1:0]   point_y;
  logic signed [psd_pkg::CoordW-1:0]   seg_start_x;
  logic signed [psd_pkg::CoordW-1:0]   seg_start_y;
  logic signed [psd_pkg::CoordW-1:0]   seg_end_x;
  logic signed [psd_pkg::CoordW-1:0]   seg_end_y;

  modport source (output valid, point_x, point_y, seg_start_x, seg_start_y,
                  seg_end_x, seg_end_y, input ready);
  modport sink   (input valid, point_x, point_y, seg_start_x, seg_start_y,
                  seg_end_x, seg_end_y, output ready);
endinterface

interface psd_out_if;
  logic                        valid;
  logic                        ready;
  logic [psd_pkg::DistW-1:0]   distance_q8;
  logic [1:0]                  nearest_part;

  modport source (output valid, distance_q8, nearest_part, input ready);
  modport sink   (input valid, distance_q8, nearest_part, output ready);
endinterface
`default_nettype wire

FILE: src/point_segment_distance_core.sv
// Point to segment distance core. Each request carries a query point P and a
// segment A..B in signed 16-bit coordinates; the result is floor(256 * |P - C|)
// with C the point of the segment nearest P, plus a code telling whether C is
// the start point (also for a zero-length segment), the interior or the end
// point. Requests enter one per cycle unless the chain holds, and results come
// out in order through 5 front stages (differences, products, case select,
// squared cross product, dividend setup), 50 division cells that form the
// squared scaled distance one quotient bit per cell, and 25 square root
// cells, one root bit per cell, the last of which is the output register. The
// whole chain holds while a result waits and the sink is not ready.
// Depends on psd_pkg, psd_if, psd_front, psd_div_cell and psd_sqrt_cell.
`default_nettype none
module point_segment_distance_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psd_in_if.sink    in_i,
  psd_out_if.source out_o
);

  logic                 en;
  psd_pkg::div_t        div_chain  [psd_pkg::QuotW+1];
  psd_pkg::sqrt_t       sqrt_chain [psd_pkg::DistW+1];

  // advance everything unless the output holds an untaken result
  assign en       = !sqrt_chain[psd_pkg::DistW].valid || out_o.ready;
  assign in_i.ready = en;

  psd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .px_i    (in_i.point_x),
    .py_i    (in_i.point_y),
    .ax_i    (in_i.seg_start_x),
    .ay_i    (in_i.seg_start_y),
    .bx_i    (in_i.seg_end_x),
    .by_i    (in_i.seg_end_y),
    .div_o   (div_chain[0])
  );

  // division chain: squared scaled distance, one quotient bit per cell
  for (genvar i = 0; i < psd_pkg::QuotW; i++) begin : g_div
    psd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (div_chain[i]),
      .q_o    (div_chain[i+1])
    );
  end

  // hand the quotient over as the radicand
  always_comb begin
    sqrt_chain[0].valid = div_chain[psd_pkg::QuotW].valid;
    sqrt_chain[0].part  = div_chain[psd_pkg::QuotW].part;
    sqrt_chain[0].rad   = div_chain[psd_pkg::QuotW].num;
    sqrt_chain[0].rem   = '0;
    sqrt_chain[0].root  = '0;
  end

  // square root chain, one result bit per cell
  for (genvar j = 0; j < psd_pkg::DistW; j++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (sqrt_chain[j]),
      .q_o    (sqrt_chain[j+1])
    );
  end

  assign out_o.valid        = sqrt_chain[psd_pkg::DistW].valid;
  assign out_o.distance_q8  = sqrt_chain[psd_pkg::DistW].root;
  assign out_o.nearest_part = sqrt_chain[psd_pkg::DistW].part;

endmodule
`default_nettype wire

FILE: src/psd_front.sv
// Front pipeline of the distance core: differences, products, case select,
// squared cross product and dividend setup. Depends on psd_pkg.
`default_nettype none
module psd_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic signed [psd_pkg::CoordW-1:0]   px_i,
  input  wire logic signed [psd_pkg::CoordW-1:0]   py_i,
  input  wire logic signed [psd_pkg::CoordW-1:0]   ax_i,
  input  wire logic signed [psd_pkg::CoordW-1:0]   ay_i,
  input  wire logic signed [psd_pkg::CoordW-1:0]   bx_i,
  input  wire logic signed [psd_pkg::CoordW-1:0]   by_i,
  output psd_pkg::div_t                            div_o
);

  // stage A: differences
  logic                              va_q;
  logic signed [psd_pkg::DiffW-1:0]  dx_q, dy_q, qx_q, qy_q, ex_q, ey_q;
  // stage B: products
  logic                              vb_q;
  logic signed [psd_pkg::ProdW-1:0]  dxdx_q, dydy_q, qxdx_q, qydy_q, qxdy_q, qydx_q;
  logic signed [psd_pkg::ProdW-1:0]  qxqx_q, qyqy_q, exex_q, eyey_q;
  // stage C: case select
  logic                              vc_q;
  psd_pkg::part_e                    partc_q;
  logic [psd_pkg::AcrW-1:0]          acr_q;
  logic [psd_pkg::LenW-1:0]          len2c_q, d2c_q;
  // stage D: partial products of the squared cross
  logic                              vd_q;
  psd_pkg::part_e                    partd_q;
  logic [2*psd_pkg::HalfW-1:0]       hh_q, hl_q, ll_q;
  logic [psd_pkg::LenW-1:0]          len2d_q, d2d_q;
  // stage E: dividend and divisor
  logic                              ve_q;
  psd_pkg::div_t                     div_q;

  logic signed [psd_pkg::SumW-1:0]   dot_c, cross_c;
  logic signed [psd_pkg::SumW-1:0]   abs_c;
  logic [psd_pkg::LenW-1:0]          len2_c, d2a_c, d2b_c;
  psd_pkg::part_e                    part_c;
  logic [psd_pkg::HalfW-1:0]         hi_c, lo_c;
  logic [psd_pkg::Cross2W-1:0]       cross2_e;
  logic [psd_pkg::Cross2W+psd_pkg::FracW-1:0] r_e;
  logic [psd_pkg::LenW-1:0]          den_e;

  always_comb begin
    len2_c  = dxdx_q[psd_pkg::LenW-1:0] + dydy_q[psd_pkg::LenW-1:0];
    d2a_c   = qxqx_q[psd_pkg::LenW-1:0] + qyqy_q[psd_pkg::LenW-1:0];
    d2b_c   = exex_q[psd_pkg::LenW-1:0] + eyey_q[psd_pkg::LenW-1:0];
    dot_c   = psd_pkg::SumW'(qxdx_q) + psd_pkg::SumW'(qydy_q);
    cross_c = psd_pkg::SumW'(qxdy_q) - psd_pkg::SumW'(qydx_q);
    abs_c   = cross_c[psd_pkg::SumW-1] ? -cross_c : cross_c;
    if (len2_c == '0 || dot_c[psd_pkg::SumW-1] || dot_c == '0) begin
      part_c = psd_pkg::PartStart;
    end else if (dot_c >= $signed({2'b00, len2_c})) begin
      part_c = psd_pkg::PartEnd;
    end else begin
      part_c = psd_pkg::PartInterior;
    end
  end

  always_comb begin
    hi_c = acr_q[psd_pkg::AcrW-1:psd_pkg::HalfW];
    lo_c = acr_q[psd_pkg::HalfW-1:0];
  end

  always_comb begin
    cross2_e = ({{(psd_pkg::Cross2W-2*psd_pkg::HalfW){1'b0}}, hh_q} << (2*psd_pkg::HalfW))
             + ({{(psd_pkg::Cross2W-2*psd_pkg::HalfW){1'b0}}, hl_q} << (psd_pkg::HalfW + 1))
             +  {{(psd_pkg::Cross2W-2*psd_pkg::HalfW){1'b0}}, ll_q};
    if (partd_q == psd_pkg::PartInterior) begin
      r_e   = {cross2_e, {psd_pkg::FracW{1'b0}}};
      den_e = len2d_q;
    end else begin
      r_e   = {{(psd_pkg::Cross2W-psd_pkg::LenW){1'b0}}, d2d_q, {psd_pkg::FracW{1'b0}}};
      den_e = psd_pkg::LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= psd_pkg::DiffW'(bx_i) - psd_pkg::DiffW'(ax_i);
      dy_q <= psd_pkg::DiffW'(by_i) - psd_pkg::DiffW'(ay_i);
      qx_q <= psd_pkg::DiffW'(px_i) - psd_pkg::DiffW'(ax_i);
      qy_q <= psd_pkg::DiffW'(py_i) - psd_pkg::DiffW'(ay_i);
      ex_q <= psd_pkg::DiffW'(px_i) - psd_pkg::DiffW'(bx_i);
      ey_q <= psd_pkg::DiffW'(py_i) - psd_pkg::DiffW'(by_i);

      dxdx_q <= dx_q * dx_q;
      dydy_q <= dy_q * dy_q;
      qxdx_q <= qx_q * dx_q;
      qydy_q <= qy_q * dy_q;
      qxdy_q <= qx_q * dy_q;
      qydx_q <= qy_q * dx_q;
      qxqx_q <= qx_q * qx_q;
      qyqy_q <= qy_q * qy_q;
      exex_q <= ex_q * ex_q;
      eyey_q <= ey_q * ey_q;

      partc_q <= part_c;
      acr_q   <= abs_c[psd_pkg::AcrW-1:0];
      len2c_q <= len2_c;
      d2c_q   <= (part_c == psd_pkg::PartEnd) ? d2b_c : d2a_c;

      partd_q <= partc_q;
      hh_q    <= hi_c * hi_c;
      hl_q    <= hi_c * lo_c;
      ll_q    <= lo_c * lo_c;
      len2d_q <= len2c_q;
      d2d_q   <= d2c_q;

      div_q.part <= partd_q;
      div_q.rem  <= r_e[psd_pkg::DivNumW-1:psd_pkg::QuotW];
      div_q.num  <= r_e[psd_pkg::QuotW-1:0];
      div_q.den  <= den_e;
    end
  end

  always_comb begin
    div_o.valid = ve_q;
    div_o.part  = div_q.part;
    div_o.rem   = div_q.rem;
    div_o.num   = div_q.num;
    div_o.den   = div_q.den;
  end

endmodule
`default_nettype wire

FILE: src/psd_div_cell.sv
// One restoring division cell: one quotient bit per cell, registered.
// Depends on psd_pkg.
`default_nettype none
module psd_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire psd_pkg::div_t d_i,
  output psd_pkg::div_t      q_o
);

  logic [psd_pkg::LenW:0]   t, diff;
  logic                     ge;
  logic                     valid_q;
  psd_pkg::div_t            q_q;

  always_comb begin
    t    = {d_i.rem, d_i.num[psd_pkg::QuotW-1]};
    diff = t - {1'b0, d_i.den};
    ge   = t >= {1'b0, d_i.den};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= d_i.valid;
    end
  end

  // shift the dividend up, take the quotient bit in at the bottom
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q.part <= d_i.part;
      q_q.rem  <= ge ? diff[psd_pkg::LenW-1:0] : t[psd_pkg::LenW-1:0];
      q_q.num  <= {d_i.num[psd_pkg::QuotW-2:0], ge};
      q_q.den  <= d_i.den;
    end
  end

  always_comb begin
    q_o.valid = valid_q;
    q_o.part  = q_q.part;
    q_o.rem   = q_q.rem;
    q_o.num   = q_q.num;
    q_o.den   = q_q.den;
  end

endmodule
`default_nettype wire

FILE: src/psd_sqrt_cell.sv
// One restoring square root cell: one root bit per cell, registered.
// Depends on psd_pkg.
`default_nettype none
module psd_sqrt_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire psd_pkg::sqrt_t d_i,
  output psd_pkg::sqrt_t      q_o
);

  logic [psd_pkg::SqRemW+1:0] t, trial, diff;
  logic                       ge;
  logic                       valid_q;
  psd_pkg::sqrt_t             q_q;

  always_comb begin
    t     = {d_i.rem, d_i.rad[psd_pkg::QuotW-1 -: 2]};
    trial = {2'b00, d_i.root, 2'b01};
    diff  = t - trial;
    ge    = t >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q.part <= d_i.part;
      q_q.rad  <= {d_i.rad[psd_pkg::QuotW-3:0], 2'b00};
      q_q.rem  <= ge ? diff[psd_pkg::SqRemW-1:0] : t[psd_pkg::SqRemW-1:0];
      q_q.root <= {d_i.root[psd_pkg::DistW-2:0], ge};
    end
  end

  always_comb begin
    q_o.valid = valid_q;
    q_o.part  = q_q.part;
    q_o.rad   = q_q.rad;
    q_o.rem   = q_q.rem;
    q_o.root  = q_q.root;
  end

endmodule
`default_nettype wire
